// File: rtl/core/pkst_pkg.sv
// shared types, codes and constants of the pair keyed set table
package pkst_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int GROUP_W     = 16;
  localparam int MEMBER_W    = 16;
  localparam int TAG_W       = 48;
  localparam int COUNT_W     = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_INSERT    = 2'd0,
    ACT_REMOVE    = 2'd1,
    ACT_CHK_PAIR  = 2'd2,
    ACT_CHK_GROUP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // how a remove picks its victims
  typedef enum logic [1:0] {
    RM_PAIR   = 2'd0,
    RM_MEMBER = 2'd1,
    RM_GROUP  = 2'd2
  } rm_mode_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_WAIT = 2'd2
  } state_t;

  // one transaction travelling down the cell chain
  typedef struct packed {
    logic                active;
    action_t             action;
    rm_mode_t            rm_mode;
    logic [GROUP_W-1:0]  group_id;
    logic [MEMBER_W-1:0] member_id;
    logic [TAG_W-1:0]    tag;
    logic                hit;
    logic                placed;
    logic [COUNT_W-1:0]  removed_count;
  } token_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic commit;
    logic cancel;
  } ctl_t;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic [COUNT_W-1:0] removed_count;
  } res_t;

endpackage

// File: rtl/core/pkst_in_if.sv
// input channel of the pair keyed set table
interface pkst_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [pkst_pkg::GROUP_W-1:0]  group_id;
  logic [pkst_pkg::MEMBER_W-1:0] member_id;
  logic [pkst_pkg::TAG_W-1:0]    tag;

  modport source (output valid, output action, output group_id, output member_id,
                  output tag, input ready);
  modport sink (input valid, input action, input group_id, input member_id,
                input tag, output ready);
endinterface

// File: rtl/core/pkst_out_if.sv
// result channel of the pair keyed set table
interface pkst_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic                         found;
  logic [pkst_pkg::COUNT_W-1:0] removed_count;

  modport source (output valid, output status, output found, output removed_count,
                  input ready);
  modport sink (input valid, input status, input found, input removed_count,
                output ready);
endinterface

// File: rtl/core/pkst_cell.sv
// one table entry: compares the passing transaction and hands it on
module pkst_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  pkst_pkg::token_t tok_i,
  input  pkst_pkg::ctl_t   ctl_i,
  output pkst_pkg::token_t tok_o,
  output logic             pending_o
);

  logic                                valid_r, valid_nxt;
  logic                                pending_r, pending_nxt;
  logic [pkst_pkg::GROUP_W-1:0]        group_r;
  logic [pkst_pkg::MEMBER_W-1:0]       member_r;
  logic [pkst_pkg::TAG_W-1:0]          tag_r;
  pkst_pkg::token_t                    tok_r, tok_nxt;
  logic                                claim;
  logic                                m_group, m_member, m_pair, rm_hit;

  assign m_group  = valid_r && (group_r == tok_i.group_id);
  assign m_member = valid_r && (member_r == tok_i.member_id);
  assign m_pair   = m_group && m_member;

  always_comb begin
    tok_nxt     = tok_i;
    valid_nxt   = valid_r;
    pending_nxt = pending_r;
    claim       = 1'b0;
    rm_hit      = 1'b0;
    // insert is settled at the tail of the chain
    if (ctl_i.commit && pending_r) valid_nxt = 1'b1;
    if (ctl_i.commit || ctl_i.cancel) pending_nxt = 1'b0;
    if (tok_i.active) begin
      unique case (tok_i.action)
        pkst_pkg::ACT_INSERT: begin
          if (m_pair) tok_nxt.hit = 1'b1;
          if (!valid_r && !pending_r && !tok_i.placed) begin
            claim          = 1'b1;
            pending_nxt    = 1'b1;
            tok_nxt.placed = 1'b1;
          end
        end
        pkst_pkg::ACT_REMOVE: begin
          unique case (tok_i.rm_mode)
            pkst_pkg::RM_PAIR:   rm_hit = m_pair;
            pkst_pkg::RM_MEMBER: rm_hit = m_member;
            pkst_pkg::RM_GROUP:  rm_hit = m_group;
            default:             rm_hit = 1'b0;
          endcase
          if (rm_hit) begin
            valid_nxt   = 1'b0;
            tok_nxt.hit = 1'b1;
            if (tok_i.removed_count != pkst_pkg::COUNT_MAX)
              tok_nxt.removed_count = tok_i.removed_count + 1'b1;
          end
        end
        pkst_pkg::ACT_CHK_PAIR:  if (m_pair) tok_nxt.hit = 1'b1;
        pkst_pkg::ACT_CHK_GROUP: if (m_group) tok_nxt.hit = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      pending_r <= 1'b0;
      tok_r     <= '0;
    end else begin
      valid_r   <= valid_nxt;
      pending_r <= pending_nxt;
      tok_r     <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      group_r  <= tok_i.group_id;
      member_r <= tok_i.member_id;
      tag_r    <= tok_i.tag;
    end
  end

  assign tok_o     = tok_r;
  assign pending_o = pending_r;

  // the stored tag is kept with the entry but never compared
  logic tag_unused;
  assign tag_unused = ^tag_r;

  a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> !valid_r)
    else $error("claimed entry already valid");

  a_quiet_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!tok_i.active && !ctl_i.commit) |=> $stable(valid_r))
    else $error("entry valid changed without a transaction");

  a_settle_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.commit || ctl_i.cancel) |-> !tok_i.active)
    else $error("settle pulse while a transaction is in the cell");

endmodule

// File: rtl/core/pkst_ctrl.sv
// sequencer: injects a transaction, waits for the chain tail, holds the result
module pkst_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [pkst_pkg::GROUP_W-1:0]  in_group_id,
  input  logic [pkst_pkg::MEMBER_W-1:0] in_member_id,
  input  logic [pkst_pkg::TAG_W-1:0]    in_tag,
  output pkst_pkg::token_t              head_o,
  input  pkst_pkg::token_t              tail_i,
  output pkst_pkg::ctl_t                ctl_o,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pkst_pkg::res_t                out_res
);

  pkst_pkg::state_t state_r, state_nxt;
  pkst_pkg::token_t head_r, head_nxt;
  pkst_pkg::res_t   res_c, res_r, out_res_r, out_res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free, load_out, load_res;
  logic             accept;

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pkst_pkg::S_IDLE: if (in_valid) state_nxt = pkst_pkg::S_SCAN;
      pkst_pkg::S_SCAN: if (tail_i.active)
                          state_nxt = out_free ? pkst_pkg::S_IDLE : pkst_pkg::S_WAIT;
      pkst_pkg::S_WAIT: if (out_free) state_nxt = pkst_pkg::S_IDLE;
      default:          state_nxt = pkst_pkg::S_IDLE;
    endcase
  end

  // result of the finished transaction
  always_comb begin
    res_c = '{status: pkst_pkg::ST_OK, found: 1'b0, removed_count: '0};
    unique case (tail_i.action)
      pkst_pkg::ACT_INSERT: begin
        if (tail_i.hit)          res_c.status = pkst_pkg::ST_DUP;
        else if (!tail_i.placed) res_c.status = pkst_pkg::ST_FULL;
      end
      pkst_pkg::ACT_REMOVE: begin
        res_c.removed_count = tail_i.removed_count;
        if (tail_i.rm_mode == pkst_pkg::RM_PAIR && !tail_i.hit)
          res_c.status = pkst_pkg::ST_NOTFOUND;
      end
      pkst_pkg::ACT_CHK_PAIR:  res_c.found = tail_i.hit;
      pkst_pkg::ACT_CHK_GROUP: res_c.found = tail_i.hit;
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    ctl_o        = '0;
    load_out     = 1'b0;
    load_res     = 1'b0;
    unique case (state_r)
      pkst_pkg::S_IDLE: in_ready = 1'b1;
      pkst_pkg::S_SCAN: begin
        if (tail_i.active) begin
          ctl_o.commit = (tail_i.action == pkst_pkg::ACT_INSERT) && tail_i.placed
                         && !tail_i.hit;
          ctl_o.cancel = (tail_i.action == pkst_pkg::ACT_INSERT) && tail_i.placed
                         && tail_i.hit;
          load_out = out_free;
          load_res = !out_free;
        end
      end
      pkst_pkg::S_WAIT: load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    head_nxt        = head_r;
    head_nxt.active = 1'b0;
    if (accept) begin
      head_nxt.active        = 1'b1;
      head_nxt.action        = pkst_pkg::action_t'(in_action);
      head_nxt.group_id      = in_group_id;
      head_nxt.member_id     = in_member_id;
      head_nxt.tag           = in_tag;
      head_nxt.hit           = 1'b0;
      head_nxt.placed        = 1'b0;
      head_nxt.removed_count = '0;
      // zero acts as a wildcard in a remove, group zero wins
      if (in_group_id == '0)       head_nxt.rm_mode = pkst_pkg::RM_MEMBER;
      else if (in_member_id == '0) head_nxt.rm_mode = pkst_pkg::RM_GROUP;
      else                         head_nxt.rm_mode = pkst_pkg::RM_PAIR;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = (state_r == pkst_pkg::S_WAIT) ? res_r : res_c;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (load_res) res_r <= res_c;
    if (!rst_n) begin
      state_r     <= pkst_pkg::S_IDLE;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign head_o    = head_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail_i.active |-> state_r == pkst_pkg::S_SCAN)
    else $error("chain tail arrived outside a scan");

  a_settle_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl_o.commit && ctl_o.cancel))
    else $error("commit and cancel together");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> head_r.active && state_r == pkst_pkg::S_SCAN)
    else $error("accepted transaction not injected");

endmodule

// File: rtl/core/pair_keyed_set_table_unit.sv
// top level of the pair keyed set table: controller and chain of entry cells
//
// A table of ENTRIES records keyed by (group id, member id), each with a tag.
// in_ch carries one transaction: insert, remove (zero id is a wildcard),
// check pair present or check group present. out_ch returns one result per
// transaction: status, found flag and removed count.
// Each transaction runs down a chain of ENTRIES cells, one cell per cycle,
// each cell comparing against its own entry. An insert claims the lowest free
// cell on the way and is committed or dropped when it leaves the last cell.
// The result is registered in the output register once the transaction leaves
// the last cell. Only one transaction is in the chain at a time, so a new one
// is taken only after the last has left the chain.
// in_ch.ready is high while idle, also while a result still waits in the
// output register. If the receiver stalls, the finished result is parked,
// in_ch.ready stays low and the next transaction waits for the output
// register to drain.
// Reset (synchronous, active low) clears every entry valid bit and drops any
// transaction in flight; no clearing sweep is needed.
module pair_keyed_set_table_unit #(
  parameter int ENTRIES = pkst_pkg::ENTRIES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  pkst_in_if.sink     in_ch,
  pkst_out_if.source  out_ch
);

  // token bus between cells, index 0 is the controller's head register
  pkst_pkg::token_t tok_w [ENTRIES+1];
  logic [ENTRIES-1:0] pend_w;
  pkst_pkg::ctl_t     ctl_w;
  pkst_pkg::res_t     res_w;

  pkst_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_action    (in_ch.action),
    .in_group_id  (in_ch.group_id),
    .in_member_id (in_ch.member_id),
    .in_tag       (in_ch.tag),
    .head_o       (tok_w[0]),
    .tail_i       (tok_w[ENTRIES]),
    .ctl_o        (ctl_w),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_res      (res_w)
  );

  // one cell per entry, each passing the transaction to the next
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pkst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_i     (tok_w[i]),
      .ctl_i     (ctl_w),
      .tok_o     (tok_w[i+1]),
      .pending_o (pend_w[i])
    );
  end

  assign out_ch.status        = res_w.status;
  assign out_ch.found         = res_w.found;
  assign out_ch.removed_count = res_w.removed_count;

  // an insert claims a single entry
  a_one_claim: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pend_w) <= 1)
    else $error("more than one entry claimed");

  // no claim is left unsettled while the controller is ready for a new transaction
  a_claim_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_w != '0 && in_ch.ready) |-> (ctl_w.commit || ctl_w.cancel))
    else $error("claimed entry left unsettled");

  a_settle_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_w.commit || ctl_w.cancel) |-> tok_w[ENTRIES].active)
    else $error("settle pulse without chain tail");

endmodule

// File: tb/sv/pair_keyed_set_table_unit_test.sv
// self-checking testbench of the pair keyed set table: directed cases, then random traffic
module pair_keyed_set_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pkst_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  // covers one pass of a transaction through the chain
  localparam int CHAIN_CYCLES = ENTRIES + 2;
  // slowest legal run: ~2100 transactions, each with the longest sender gap, the
  // longest receiver stall and the chain latency, taken several times over
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned RANDOM_OPS = 2000;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_THIRD, RX_LONG_STALL} rx_mode_t;

  logic clk;
  logic rst_n;

  pkst_in_if  in_ch ();
  pkst_out_if out_ch ();

  pair_keyed_set_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the table contents
  bit                  slot_live   [ENTRIES];
  logic [GROUP_W-1:0]  slot_group  [ENTRIES];
  logic [MEMBER_W-1:0] slot_member [ENTRIES];
  logic [TAG_W-1:0]    slot_tag    [ENTRIES];

  // results predicted for accepted transactions, oldest first
  res_t        pending_results[$];
  int unsigned mismatch_count = 0;

  // free-running clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow table
  // ---------------------------------------------------------------------------

  // index of the live slot holding the exact pair, -1 when absent
  function automatic int find_pair(logic [GROUP_W-1:0] g, logic [MEMBER_W-1:0] m);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && slot_group[i] == g && slot_member[i] == m) return i;
    end
    return -1;
  endfunction

  // apply one transaction to the shadow table and give the result it must produce
  function automatic res_t apply_table_op(action_t act, logic [GROUP_W-1:0] g,
                                          logic [MEMBER_W-1:0] m, logic [TAG_W-1:0] tag);
    res_t        r;
    int unsigned hits;
    bit          hit;
    r.status        = ST_OK;
    r.found         = 1'b0;
    r.removed_count = '0;
    hits            = 0;
    case (act)
      ACT_INSERT: begin
        // duplicate wins over full
        if (find_pair(g, m) >= 0) begin
          r.status = ST_DUP;
        end else begin
          r.status = ST_FULL;
          // lowest free slot takes the record
          for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_live[i]) begin
              slot_live[i]   = 1'b1;
              slot_group[i]  = g;
              slot_member[i] = m;
              slot_tag[i]    = tag;
              r.status       = ST_OK;
              break;
            end
          end
        end
      end
      ACT_REMOVE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (g != '0 && m != '0) hit = slot_group[i] == g && slot_member[i] == m;
          else if (g == '0)       hit = slot_member[i] == m;
          else                    hit = slot_group[i] == g;
          if (slot_live[i] && hit) begin
            slot_live[i] = 1'b0;
            hits++;
          end
        end
        // only the exact form reports a miss
        if (g != '0 && m != '0 && hits == 0) r.status = ST_NOTFOUND;
        r.removed_count = (hits > COUNT_MAX) ? COUNT_MAX : hits[COUNT_W-1:0];
      end
      ACT_CHK_PAIR: begin
        r.found = find_pair(g, m) >= 0;
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_live[i] && slot_group[i] == g) r.found = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // a random live slot, -1 when the table is empty
  function automatic int random_live_slot();
    int live[$];
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i]) live.push_back(i);
    end
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // key and tag generation: mostly a small pool so that keys collide
  // ---------------------------------------------------------------------------

  function automatic logic [GROUP_W-1:0] pick_group();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return GROUP_W'($urandom_range(1, 4));
    if (r < 78) return '0;
    if (r < 85) return '1;
    return GROUP_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [MEMBER_W-1:0] pick_member();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return MEMBER_W'($urandom_range(1, 16));
    if (r < 78) return '0;
    if (r < 85) return '1;
    return MEMBER_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [TAG_W-1:0] random_tag();
    logic [TAG_W-1:0] t;
    t[TAG_W-1:32] = (TAG_W-32)'($urandom_range(0, 16'hFFFF));
    t[31:0]       = $urandom;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // present one transaction at the falling edge and hold it until accepted;
  // valid stays high on return so a back-to-back transaction follows cleanly
  task automatic submit_table_op(action_t act, logic [GROUP_W-1:0] g,
                                 logic [MEMBER_W-1:0] m, logic [TAG_W-1:0] tag);
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.group_id  <= g;
    in_ch.member_id <= m;
    in_ch.tag       <= tag;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(apply_table_op(act, g, m, tag));
  endtask

  // drop valid for a number of cycles
  task automatic idle_sender(int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // hold off until every predicted result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual status %0d found %0d count %0d",
               $time, out_ch.status, out_ch.found, out_ch.removed_count);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      if (out_ch.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, out_ch.status);
        mismatch_count++;
      end
      if (out_ch.found !== want.found) begin
        $display("%0t: found mismatch: expected %0d, actual %0d",
                 $time, want.found, out_ch.found);
        mismatch_count++;
      end
      if (out_ch.removed_count !== want.removed_count) begin
        $display("%0t: removed_count mismatch: expected %0d, actual %0d",
                 $time, want.removed_count, out_ch.removed_count);
        mismatch_count++;
      end
    end
  endtask

  // checks every result transaction at the rising edge and moves the receiver
  // through stall patterns of varying length at the falling edge
  initial begin : result_monitor
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold;
    mode          = RX_OPEN;
    mode_left     = 0;
    hold          = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (mode)
        RX_OPEN:        out_ch.ready <= 1'b1;
        RX_COIN:        out_ch.ready <= 1'($urandom_range(0, 1));
        RX_EVERY_THIRD: out_ch.ready <= (mode_left % 3 == 0);
        default: begin
          // long stall, then a single open cycle
          if (hold == 0) begin
            out_ch.ready <= 1'b1;
            hold = $urandom_range(1, 100);
          end else begin
            out_ch.ready <= 1'b0;
            hold--;
          end
        end
      endcase
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // nothing is present right after reset, zero keys included
  task automatic test_empty_table();
    submit_table_op(ACT_CHK_PAIR,  16'd1, 16'd1, '0);
    submit_table_op(ACT_CHK_GROUP, 16'd1, 16'd0, '0);
    submit_table_op(ACT_CHK_PAIR,  16'd0, 16'd0, '0);
    submit_table_op(ACT_CHK_GROUP, 16'd0, 16'd0, '0);
    submit_table_op(ACT_REMOVE,    16'd1, 16'd1, '0);  // exact miss
    submit_table_op(ACT_REMOVE,    16'd0, 16'd0, '0);  // wildcard, nothing to take
  endtask

  // extreme keys and tags, duplicate pair refused, checks compare exactly
  task automatic test_insert_duplicate();
    submit_table_op(ACT_INSERT,    16'd0,    16'd0,    '0);
    submit_table_op(ACT_INSERT,    16'hFFFF, 16'hFFFF, '1);
    submit_table_op(ACT_INSERT,    16'd0,    16'd0,    random_tag());
    submit_table_op(ACT_CHK_PAIR,  16'd0,    16'd0,    '1);
    submit_table_op(ACT_CHK_PAIR,  16'hFFFF, 16'hFFFF, '0);
    submit_table_op(ACT_CHK_GROUP, 16'hFFFF, 16'hFFFF, '0);
    submit_table_op(ACT_CHK_PAIR,  16'hFFFF, 16'd0,    '0);  // zero is no wildcard here
  endtask

  // exact remove: hit, then the same pair misses
  task automatic test_exact_remove();
    submit_table_op(ACT_REMOVE,    16'hFFFF, 16'hFFFF, '0);
    submit_table_op(ACT_REMOVE,    16'hFFFF, 16'hFFFF, '0);
    submit_table_op(ACT_CHK_GROUP, 16'hFFFF, 16'd0,    '0);
  endtask

  // removes by member, by group, member zero across groups, and empty wildcards
  task automatic test_wildcard_remove();
    submit_table_op(ACT_INSERT, 16'd5, 16'd7, random_tag());
    submit_table_op(ACT_INSERT, 16'd6, 16'd7, random_tag());
    submit_table_op(ACT_INSERT, 16'd5, 16'd8, random_tag());
    submit_table_op(ACT_REMOVE, 16'd0, 16'd7, '1);
    submit_table_op(ACT_REMOVE, 16'd5, 16'd0, '1);
    submit_table_op(ACT_REMOVE, 16'd0, 16'd0, '0);
    submit_table_op(ACT_REMOVE, 16'd9, 16'd0, '0);
    submit_table_op(ACT_REMOVE, 16'd0, 16'd9, '0);
  endtask

  // fill to capacity: full refusal, duplicate on a full table, reuse of a freed
  // slot, then one group remove that takes every record
  task automatic test_table_capacity();
    localparam logic [GROUP_W-1:0] FILL_GROUP = 16'h0C3A;
    int unsigned live;
    live = 0;
    foreach (slot_live[i]) live += slot_live[i];
    for (int i = 1; i <= ENTRIES - int'(live); i++) begin
      submit_table_op(ACT_INSERT, FILL_GROUP, MEMBER_W'(i), random_tag());
    end
    submit_table_op(ACT_INSERT,    FILL_GROUP, 16'hFFFE, random_tag());  // full
    submit_table_op(ACT_INSERT,    FILL_GROUP, 16'd1,    random_tag());  // duplicate beats full
    submit_table_op(ACT_REMOVE,    FILL_GROUP, 16'd10,   '0);
    submit_table_op(ACT_INSERT,    16'd77,     16'd77,   random_tag());
    submit_table_op(ACT_INSERT,    16'd78,     16'd78,   random_tag());  // full again
    submit_table_op(ACT_REMOVE,    16'd0,      16'd77,   '0);
    submit_table_op(ACT_REMOVE,    FILL_GROUP, 16'd0,    '0);
    submit_table_op(ACT_CHK_GROUP, FILL_GROUP, 16'd0,    '0);
  endtask

  // alternating fill-heavy and drain-heavy phases with bursty sending; between
  // phases the sender holds off until the pipeline has drained
  task automatic test_random_traffic(int unsigned n_ops);
    int unsigned      done;
    int unsigned      phase_left;
    int unsigned      burst_left;
    bit               filling;
    int               r;
    int               slot;
    action_t          act;
    logic [GROUP_W-1:0]  g;
    logic [MEMBER_W-1:0] m;
    done       = 0;
    phase_left = 0;
    burst_left = 0;
    filling    = 1'b0;
    while (done < n_ops) begin
      if (phase_left == 0) begin
        if (done != 0) wait_for_results();
        filling    = !filling;
        phase_left = $urandom_range(120, 260);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        // some bursts follow straight on
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 90));
      end
      burst_left--;
      phase_left--;

      r = $urandom_range(0, 99);
      if (filling) begin
        if (r < 65)      act = ACT_INSERT;
        else if (r < 75) act = ACT_CHK_PAIR;
        else if (r < 85) act = ACT_CHK_GROUP;
        else             act = ACT_REMOVE;
      end else begin
        if (r < 25)      act = ACT_INSERT;
        else if (r < 40) act = ACT_CHK_PAIR;
        else if (r < 55) act = ACT_CHK_GROUP;
        else             act = ACT_REMOVE;
      end

      g    = pick_group();
      m    = pick_member();
      slot = random_live_slot();
      case (act)
        ACT_INSERT: begin
          // now and then aim at a stored pair
          if (slot >= 0 && $urandom_range(0, 99) < 15) begin
            g = slot_group[slot];
            m = slot_member[slot];
          end
        end
        ACT_REMOVE: begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            if (slot >= 0 && $urandom_range(0, 1) == 1) begin
              g = slot_group[slot];
              m = slot_member[slot];
            end
          end else if (r < 75) begin
            m = '0;  // whole group
          end else if (r < 95) begin
            g = '0;  // every record of one member id
          end else begin
            g = '0;
            m = '0;
          end
        end
        default: begin
          if (slot >= 0 && $urandom_range(0, 1) == 1) begin
            g = slot_group[slot];
            m = slot_member[slot];
          end
        end
      endcase
      submit_table_op(act, g, m, random_tag());
      done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_INSERT;
    in_ch.group_id  = '0;
    in_ch.member_id = '0;
    in_ch.tag       = '0;
    rst_n           = 1'b0;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_insert_duplicate();
    test_exact_remove();
    test_wildcard_remove();
    test_table_capacity();
    wait_for_results();
    test_random_traffic(RANDOM_OPS);

    // let anything stray show up before the verdict
    wait_for_results();
    repeat (2 * CHAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pkst_pkg.sv
rtl/core/pkst_in_if.sv
rtl/core/pkst_out_if.sv
rtl/core/pkst_cell.sv
rtl/core/pkst_ctrl.sv
rtl/core/pair_keyed_set_table_unit.sv
tb/sv/pair_keyed_set_table_unit_test.sv
